// ----- hw/rtl/hrhs_pkg.sv -----
// shared types, constants and pattern tables of the response header scanner
`timescale 1ns / 1ps

package hrhs_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int WIN_LEN         = 12;
    localparam int NAME_LEN        = 10;
    localparam int CAP_WIDTH       = 16;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'd4096;

    // item kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_PEER  = 2'd2;

    // characters
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // value scan phases after the header name
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_BLANK = 3'd1;
    localparam logic [2:0] PH_C     = 3'd2;
    localparam logic [2:0] PH_CL    = 3'd3;
    localparam logic [2:0] PH_CLO   = 3'd4;
    localparam logic [2:0] PH_CLOS  = 3'd5;

    // header name, oldest byte first; first ten compared case-folded
    localparam logic [7:0] NAME_PAT [WIN_LEN] = '{
        8'h63, 8'h6f, 8'h6e, 8'h6e, 8'h65, 8'h63, 8'h74, 8'h69, 8'h6f, 8'h6e,
        CH_COLON, CH_SPACE
    };

    // blank line terminator sits in the last four window positions
    localparam logic [7:0] TERM_PAT [WIN_LEN] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        CH_CR, CH_LF, CH_CR, CH_LF
    };
    localparam int TERM_FIRST = 8;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_out;
        logic        header_finished;
        logic        close_requested;
        logic        output_full;
        logic [15:0] body_length;
    } t_result;

endpackage

// ----- hw/rtl/hrhs_if.sv -----
// stream interfaces for received items and scan results
`timescale 1ns / 1ps

interface hrhs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface hrhs_out_if;
    logic        valid;
    logic        ready;
    logic        body_valid;
    logic [7:0]  body_out;
    logic        header_finished;
    logic        close_requested;
    logic        output_full;
    logic [15:0] body_length;

    modport source (output valid, output body_valid, output body_out,
                    output header_finished, output close_requested,
                    output output_full, output body_length, input ready);
    modport sink   (input valid, input body_valid, input body_out,
                    input header_finished, input close_requested,
                    input output_full, input body_length, output ready);
endinterface

// ----- hw/rtl/hrhs_win_cell.sv -----
// one byte of the header history window with its pattern compares
`timescale 1ns / 1ps

module hrhs_win_cell #(
    parameter logic [7:0] P_NAME = 8'h00,
    parameter bit         P_FOLD = 1'b0,
    parameter logic [7:0] P_TERM = 8'h00
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hrhs_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]          i_d,
    output logic [7:0]          o_q,
    output logic                o_name_hit,
    output logic                o_term_hit
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = '0;
        end else if (i_ctl.shift) begin
            n_byte = i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    // hits look at the byte this cell takes on the next shift
    assign o_name_hit = P_FOLD ? ((i_d | hrhs_pkg::CASE_BIT) == P_NAME) : (i_d == P_NAME);
    assign o_term_hit = (i_d == P_TERM);
    assign o_q        = r_byte;

endmodule

// ----- hw/rtl/http_response_header_scanner_core.sv -----
// top level of the http response header scanner
`timescale 1ns / 1ps

// channel   | direction | handshake     | payload
// i_in      | in        | valid / ready | kind, rx_byte
// o_out     | out       | valid / ready | body_valid, body_out, header_finished,
//           |           |               | close_requested, output_full, body_length
// i_cfg_*   | in        | write enable  | body_capacity (16 bit)
//
// one item per cycle while ready is high; the window compare and phase update are
// combinational, and the result is registered into the main or the skid entry.
// a two-entry output buffer (main + skid) keeps input flowing while a result
// waits; ready drops only when both entries are full.
// i_rst_n is synchronous, active low; clears all but r_main/r_skid; capacity 4096.
module http_response_header_scanner_core #(
    parameter int COUNT_WIDTH = hrhs_pkg::COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hrhs_in_if.sink           i_in,
    hrhs_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata
);

    localparam int WL = hrhs_pkg::WIN_LEN;
    // wide enough for count, capacity and the +1 without wrapping
    localparam int LW = ((COUNT_WIDTH > hrhs_pkg::CAP_WIDTH) ? COUNT_WIDTH
                                                           : hrhs_pkg::CAP_WIDTH) + 1;

    // ---------------------------------------------------------------------
    // state
    // ---------------------------------------------------------------------
    logic [15:0]            r_cap;
    logic                   r_in_body, n_in_body;
    logic [2:0]             r_phase, n_phase;
    logic                   r_close, n_close;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_full, n_full;

    // output buffer
    hrhs_pkg::t_result      r_main, r_skid, n_res;
    logic                   r_main_v, r_skid_v;

    logic                   accept, pop;
    logic                   is_byte, is_start, is_peer;
    logic                   hdr_byte;
    logic [7:0]             b;

    assign i_in.ready = !r_skid_v;
    assign accept     = i_in.valid && i_in.ready;
    assign pop        = r_main_v && o_out.ready;
    assign b          = i_in.rx_byte;
    assign is_byte    = (i_in.kind == hrhs_pkg::KIND_BYTE);
    assign is_start   = (i_in.kind == hrhs_pkg::KIND_START);
    assign is_peer    = (i_in.kind == hrhs_pkg::KIND_PEER);
    assign hdr_byte   = accept && is_byte && !r_in_body;

    // ---------------------------------------------------------------------
    // history window: chain of cells, newest byte enters at the top end
    // ---------------------------------------------------------------------
    hrhs_pkg::t_cell_ctl cell_ctl;
    logic [7:0]          win_q    [WL];
    logic [7:0]          win_d    [WL];
    logic [WL-1:0]       name_hit;
    logic [WL-1:0]       term_hit;
    logic                name_match, term_match;

    assign cell_ctl.shift = hdr_byte;
    assign cell_ctl.clear = accept && is_start;

    genvar k;
    generate
        for (k = 0; k < WL; k++) begin : g_cell
            if (k == WL - 1) begin : g_head
                assign win_d[k] = b;
            end else begin : g_link
                assign win_d[k] = win_q[k+1];
            end
            hrhs_win_cell #(
                .P_NAME (hrhs_pkg::NAME_PAT[k]),
                .P_FOLD (k < hrhs_pkg::NAME_LEN),
                .P_TERM (hrhs_pkg::TERM_PAT[k])
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (cell_ctl),
                .i_d        (win_d[k]),
                .o_q        (win_q[k]),
                .o_name_hit (name_hit[k]),
                .o_term_hit (term_hit[k])
            );
        end
    endgenerate

    // both checks look at the window as it stands after this byte
    assign name_match = &name_hit;
    assign term_match = &term_hit[WL-1:hrhs_pkg::TERM_FIRST];

    // ---------------------------------------------------------------------
    // body limit checks
    // ---------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   lim_now, lim_after;

    assign cnt_inc   = r_count + COUNT_WIDTH'(1);
    assign lim_now   = ((LW'(r_count) + LW'(1)) >= LW'(r_cap)) || (&r_count);
    assign lim_after = ((LW'(cnt_inc) + LW'(1)) >= LW'(r_cap)) || (&cnt_inc);

    // ---------------------------------------------------------------------
    // next state and result
    // ---------------------------------------------------------------------
    logic       pass;
    logic [2:0] scan_phase;

    // close value scan on a header byte, before the window check overrides it
    always_comb begin
        scan_phase = hrhs_pkg::PH_IDLE;
        n_close    = r_close;
        case (r_phase)
            hrhs_pkg::PH_BLANK: begin
                if (b == hrhs_pkg::CH_SPACE || b == hrhs_pkg::CH_TAB) begin
                    scan_phase = hrhs_pkg::PH_BLANK;
                end else if (b == hrhs_pkg::CH_C) begin
                    scan_phase = hrhs_pkg::PH_C;
                end
            end
            hrhs_pkg::PH_C: begin
                if (b == hrhs_pkg::CH_L) scan_phase = hrhs_pkg::PH_CL;
            end
            hrhs_pkg::PH_CL: begin
                if (b == hrhs_pkg::CH_O) scan_phase = hrhs_pkg::PH_CLO;
            end
            hrhs_pkg::PH_CLO: begin
                if (b == hrhs_pkg::CH_S) scan_phase = hrhs_pkg::PH_CLOS;
            end
            hrhs_pkg::PH_CLOS: begin
                if (b == hrhs_pkg::CH_E) n_close = 1'b1;
            end
            default: begin
                scan_phase = hrhs_pkg::PH_IDLE;
            end
        endcase
        if (!hdr_byte) begin
            n_close = r_close;
        end
        if (accept && is_peer) begin
            n_close = 1'b1;
        end
        if (accept && is_start) begin
            n_close = 1'b0;
        end
    end

    always_comb begin
        n_in_body = r_in_body;
        n_phase   = r_phase;
        n_count   = r_count;
        n_full    = r_full;
        pass      = 1'b0;
        if (accept && is_start) begin
            n_in_body = 1'b0;
            n_phase   = hrhs_pkg::PH_IDLE;
            n_count   = '0;
            n_full    = 1'b0;
        end else if (hdr_byte) begin
            n_phase = scan_phase;
            if (name_match) n_phase = hrhs_pkg::PH_BLANK;
            if (term_match) begin
                n_in_body = 1'b1;
                n_phase   = hrhs_pkg::PH_IDLE;
            end
        end else if (accept && is_byte) begin
            // body byte: drop once full or at the limit, else pass it on
            if (r_full || lim_now) begin
                n_full = 1'b1;
            end else begin
                pass    = 1'b1;
                n_count = cnt_inc;
                n_full  = lim_after;
            end
        end
    end

    logic [LW-1:0] count_ext;
    assign count_ext = LW'(n_count);

    always_comb begin
        n_res.body_valid      = pass;
        n_res.body_out        = pass ? b : 8'h00;
        n_res.header_finished = n_in_body;
        n_res.close_requested = n_close;
        n_res.output_full     = n_full;
        n_res.body_length     = count_ext[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= hrhs_pkg::CAP_RESET;
            r_in_body <= 1'b0;
            r_phase   <= hrhs_pkg::PH_IDLE;
            r_close   <= 1'b0;
            r_count   <= '0;
            r_full    <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            r_in_body <= n_in_body;
            r_phase   <= n_phase;
            r_close   <= n_close;
            r_count   <= n_count;
            r_full    <= n_full;
        end
    end

    // ---------------------------------------------------------------------
    // output buffer: main register feeds the port, skid catches one more
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || pop) begin
            r_main_v <= r_skid_v || accept;
            r_skid_v <= 1'b0;
        end else if (accept) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_v || pop) begin
            r_main <= r_skid_v ? r_skid : n_res;
        end
        if (accept) begin
            r_skid <= n_res;
        end
    end

    assign o_out.valid           = r_main_v;
    assign o_out.body_valid      = r_main.body_valid;
    assign o_out.body_out        = r_main.body_out;
    assign o_out.header_finished = r_main.header_finished;
    assign o_out.close_requested = r_main.close_requested;
    assign o_out.output_full     = r_main.output_full;
    assign o_out.body_length     = r_main.body_length;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid entry holds a result while main register is empty");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_start) |=> (r_count == '0 && !r_in_body && !r_full && !r_close))
        else $error("start transfer left scanner state behind");

    a_pass_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pass |-> (r_in_body && !r_full && !lim_now))
        else $error("body byte passed outside body or past the limit");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_full) |-> ($past(accept && is_start) || !$past(i_rst_n)))
        else $error("full flag cleared without a start transfer");

endmodule

// ----- tb/http_response_header_scanner_core_test.sv -----
// self-checking testbench of the http response header scanner core
`timescale 1ns / 1ps

// Directed table first: reset state, unused kind, peer close, start, a full
// "Connection: close" header, name in upper case, a tab, the blank line and a
// body that runs into a capacity of 3. Then random responses over several
// capacity settings, including 0, 1 and 65535. Every accepted item is run
// through a local scan model, and each output transfer is checked against the
// oldest outstanding prediction.
module http_response_header_scanner_core_test;

    import hrhs_pkg::*;

    // kind 3 is not defined and must leave all state alone
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int          CLK_HALF        = 10;
    localparam int          HOLD_CYCLES     = 80;
    localparam int          STALL_LIMIT     = 1000;
    localparam int          TAIL_CYCLES     = 8;
    localparam int          ITEMS_PER_PHASE = 125;
    localparam int          HOLD_PHASE      = 3;
    localparam int          MAX_REPORTS     = 10;
    localparam int unsigned RESET_CAPACITY  = 4096;
    localparam int unsigned COUNT_MAX       = (1 << COUNT_WIDTH_DEF) - 1;

    // header name compared case-folded, then the tail of "close" after its c
    localparam logic [7:0] HDR_NAME [10] = '{"c", "o", "n", "n", "e", "c", "t", "i", "o", "n"};
    localparam logic [7:0] CLOSE_TAIL [4] = '{CH_L, CH_O, CH_S, CH_E};
    localparam logic [7:0] LETTER_A = "a";

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       pinned;     // exp holds a hand-typed result
        t_result    exp;
    } item_t;

    // hand-typed results for the directed table
    localparam t_result RES_IDLE   = '0;
    localparam t_result RES_CLOSED = '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 16'd0};
    localparam t_result RES_BODY   = '{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 16'd0};
    localparam t_result RES_PASS1  = '{1'b1, 8'h00, 1'b1, 1'b1, 1'b0, 16'd1};
    localparam t_result RES_PASS2  = '{1'b1, 8'hff, 1'b1, 1'b1, 1'b1, 16'd2};
    localparam t_result RES_DROP   = '{1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 16'd2};

    // walked with a capacity of 3 written right after reset
    localparam item_t DIR_TABLE [30] = '{
        '{KIND_BYTE,   8'h00, 1'b1, RES_IDLE},     // nothing set after reset
        '{KIND_UNUSED, 8'hff, 1'b1, RES_IDLE},     // unused kind is a no-op
        '{KIND_PEER,   8'h00, 1'b1, RES_CLOSED},   // peer close sets the flag
        '{KIND_BYTE,   8'hff, 1'b1, RES_CLOSED},   // bytes after peer close still scanned
        '{KIND_START,  8'h5a, 1'b1, RES_IDLE},     // start clears everything
        '{KIND_BYTE,   "C",   1'b0, RES_IDLE},     // header name in upper case
        '{KIND_BYTE,   "O",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "N",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "N",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "E",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "C",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "T",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "I",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "O",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "N",   1'b0, RES_IDLE},
        '{KIND_BYTE,   CH_COLON, 1'b0, RES_IDLE},
        '{KIND_BYTE,   CH_SPACE, 1'b0, RES_IDLE},
        '{KIND_BYTE,   CH_TAB,   1'b0, RES_IDLE},  // blank skipped before the value
        '{KIND_BYTE,   "c",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "l",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "o",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "s",   1'b0, RES_IDLE},
        '{KIND_BYTE,   "e",   1'b1, RES_CLOSED},   // close word complete
        '{KIND_BYTE,   CH_CR, 1'b0, RES_IDLE},
        '{KIND_BYTE,   CH_LF, 1'b0, RES_IDLE},
        '{KIND_BYTE,   CH_CR, 1'b0, RES_IDLE},
        '{KIND_BYTE,   CH_LF, 1'b1, RES_BODY},     // blank line ends the header
        '{KIND_BYTE,   8'h00, 1'b1, RES_PASS1},
        '{KIND_BYTE,   8'hff, 1'b1, RES_PASS2},    // capacity less one reached
        '{KIND_BYTE,   8'h80, 1'b1, RES_DROP}      // dropped once full
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    hrhs_in_if  in_ch ();
    hrhs_out_if out_ch ();

    http_response_header_scanner_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // scan model state, owned by the result checker process
    logic [7:0]  hist [12];
    bit          body_seen;
    logic [2:0]  val_phase;
    bit          close_seen;
    int unsigned pass_count;
    bit          full_seen;
    int unsigned capacity_q;

    t_result     expect_q [$];
    item_t       resp_q [$];
    int          mismatch_n;

    // sideband that rides along with each input transfer
    bit          pin_flag;
    t_result     pin_res;

    bit          src_calm;      // sender runs without gaps
    int          hold_asked;    // bumped to ask the receiver for a long hold

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // scan model
    // ------------------------------------------------------------------

    function automatic void clear_scan();
        foreach (hist[k]) hist[k] = 8'h00;
        body_seen  = 1'b0;
        val_phase  = PH_IDLE;
        close_seen = 1'b0;
        pass_count = 0;
        full_seen  = 1'b0;
    endfunction

    // no room for another body byte
    function automatic bit body_at_cap();
        return (pass_count + 1 >= capacity_q) || (pass_count >= COUNT_MAX);
    endfunction

    function automatic t_result scan_step(logic [1:0] kind, logic [7:0] b);
        t_result r;
        bit      name_hit;
        r = '0;
        case (kind)
            KIND_START: clear_scan();
            KIND_PEER:  close_seen = 1'b1;
            KIND_BYTE: begin
                if (!body_seen) begin
                    // value check after the header name
                    case (val_phase)
                        PH_BLANK: begin
                            if (b == CH_SPACE || b == CH_TAB) begin
                                val_phase = PH_BLANK;
                            end else if (b == CH_C) begin
                                val_phase = PH_C;
                            end else begin
                                val_phase = PH_IDLE;
                            end
                        end
                        PH_C, PH_CL, PH_CLO, PH_CLOS: begin
                            if (b != CLOSE_TAIL[val_phase - PH_C]) begin
                                val_phase = PH_IDLE;
                            end else if (val_phase == PH_CLOS) begin
                                close_seen = 1'b1;
                                val_phase  = PH_IDLE;
                            end else begin
                                val_phase = val_phase + 3'd1;
                            end
                        end
                        default: val_phase = PH_IDLE;
                    endcase
                    for (int k = 0; k < 11; k++) hist[k] = hist[k + 1];
                    hist[11] = b;
                    // name letters case-folded, colon and space exact
                    name_hit = (hist[10] == CH_COLON) && (hist[11] == CH_SPACE);
                    for (int k = 0; k < 10; k++) begin
                        if ((hist[k] | CASE_BIT) != HDR_NAME[k]) name_hit = 1'b0;
                    end
                    if (name_hit) val_phase = PH_BLANK;
                    if (hist[8] == CH_CR && hist[9] == CH_LF &&
                        hist[10] == CH_CR && hist[11] == CH_LF) begin
                        body_seen = 1'b1;
                        val_phase = PH_IDLE;
                    end
                end else if (full_seen || body_at_cap()) begin
                    full_seen = 1'b1;
                end else begin
                    r.body_valid = 1'b1;
                    r.body_out   = b;
                    pass_count++;
                    if (body_at_cap()) full_seen = 1'b1;
                end
            end
            default: ;
        endcase
        r.header_finished = body_seen;
        r.close_requested = close_seen;
        r.output_full     = full_seen;
        r.body_length     = pass_count[15:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic void note_mismatch(string why, t_result want, t_result seen);
        mismatch_n++;
        if (mismatch_n <= MAX_REPORTS)
            $display("tb: %s: expected v=%0b d=%02h hf=%0b cr=%0b full=%0b len=%0d,",
                     why, want.body_valid, want.body_out, want.header_finished,
                     want.close_requested, want.output_full, want.body_length,
                     " got v=%0b d=%02h hf=%0b cr=%0b full=%0b len=%0d",
                     seen.body_valid, seen.body_out, seen.header_finished,
                     seen.close_requested, seen.output_full, seen.body_length);
    endfunction

    // check the output transfer before queueing the input one, so a result
    // can never be matched against a prediction from the same edge
    always @(posedge i_clk) begin : result_check
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            clear_scan();
            capacity_q = RESET_CAPACITY;
        end else begin
            if (i_cfg_we) capacity_q = i_cfg_wdata;
            if (out_ch.valid && out_ch.ready) begin
                seen.body_valid      = out_ch.body_valid;
                seen.body_out        = out_ch.body_out;
                seen.header_finished = out_ch.header_finished;
                seen.close_requested = out_ch.close_requested;
                seen.output_full     = out_ch.output_full;
                seen.body_length     = out_ch.body_length;
                if (expect_q.size() == 0) begin
                    note_mismatch("result with nothing outstanding", '0, seen);
                end else begin
                    want = expect_q.pop_front();
                    if (want.body_valid != seen.body_valid ||
                        want.body_out != seen.body_out ||
                        want.header_finished != seen.header_finished ||
                        want.close_requested != seen.close_requested ||
                        want.output_full != seen.output_full ||
                        want.body_length != seen.body_length)
                        note_mismatch("result mismatch", want, seen);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                want = scan_step(in_ch.kind, in_ch.rx_byte);
                // typed rows still advance the model but are checked as typed
                if (pin_flag) want = pin_res;
                expect_q.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver pacing
    // ------------------------------------------------------------------

    // one random wait per transfer, with calm stretches of no waits;
    // a hold request turns the next wait into a long one
    initial begin : sink_pacing
        int n;
        int holds_done;
        bit calm;
        holds_done = 0;
        calm       = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_asked != holds_done) begin
                holds_done = hold_asked;
                n = HOLD_CYCLES;
            end else begin
                if ($urandom_range(0, 31) == 0) calm = !calm;
                n = calm ? 0 : $urandom_range(0, 16);
            end
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run after a long stretch with no transfer
    // ------------------------------------------------------------------

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // one input transfer, after a random gap unless the sender is calm
    task automatic send_item(item_t it);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= it.kind;
        in_ch.rx_byte <= it.data;
        pin_flag      <= it.pinned;
        pin_res       <= it.exp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expect_q.size() != 0) @(posedge i_clk);
    endtask

    // capacity is only written with the block idle
    task automatic set_capacity(logic [15:0] cap);
        drain();
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic void push_item(logic [1:0] kind, logic [7:0] data);
        item_t it;
        it = '{kind, data, 1'b0, '0};
        resp_q.push_back(it);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_item(KIND_BYTE, s[i]);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // occasional peer close, unused kind or stray byte
    function automatic void push_noise();
        case ($urandom_range(0, 2))
            0:       push_item(KIND_PEER, any_byte());
            1:       push_item(KIND_UNUSED, any_byte());
            default: push_item(KIND_BYTE, any_byte());
        endcase
    endfunction

    // "Connection: <value>" in random case, sometimes a near miss
    function automatic void push_connection_line();
        string word;
        int    n;
        word = "close";
        for (int k = 0; k < 10; k++)
            push_item(KIND_BYTE, HDR_NAME[k] ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00));
        push_item(KIND_BYTE, CH_COLON);
        // a tab in place of the space must not match the name
        push_item(KIND_BYTE, ($urandom_range(0, 7) == 0) ? CH_TAB : CH_SPACE);
        repeat ($urandom_range(0, 3))
            push_item(KIND_BYTE, $urandom_range(0, 1) ? CH_TAB : CH_SPACE);
        case ($urandom_range(0, 5))
            0, 1: push_text("close");
            2:    push_text("Close");
            3: begin
                // broken word: a prefix of close, then anything
                n = $urandom_range(1, 4);
                for (int j = 0; j < n; j++) push_item(KIND_BYTE, word[j]);
                push_item(KIND_BYTE, any_byte());
            end
            4:    push_text("keep-alive");
            default: repeat ($urandom_range(1, 6)) push_item(KIND_BYTE, any_byte());
        endcase
        push_item(KIND_BYTE, CH_CR);
        push_item(KIND_BYTE, CH_LF);
    endfunction

    function automatic void push_plain_line();
        repeat ($urandom_range(1, 6))
            push_item(KIND_BYTE, (LETTER_A + 8'($urandom_range(0, 25))) ^
                                 ($urandom_range(0, 1) ? CASE_BIT : 8'h00));
        push_item(KIND_BYTE, CH_COLON);
        push_item(KIND_BYTE, CH_SPACE);
        repeat ($urandom_range(0, 6)) push_item(KIND_BYTE, 8'($urandom_range(8'h20, 8'h7e)));
        push_item(KIND_BYTE, CH_CR);
        push_item(KIND_BYTE, CH_LF);
    endfunction

    // mostly well-formed responses with random content
    function automatic void build_response(bit lead_start);
        int nlines;
        int conn_at;
        int body_n;
        int sel;
        if (lead_start) push_item(KIND_START, any_byte());
        nlines  = $urandom_range(0, 2);
        conn_at = $urandom_range(0, nlines);
        for (int j = 0; j <= nlines; j++) begin
            if (j == conn_at && $urandom_range(0, 4) != 0)
                push_connection_line();
            else
                push_plain_line();
            if ($urandom_range(0, 11) == 0) push_noise();
        end
        // a stray byte before the blank line breaks the terminator
        if ($urandom_range(0, 9) == 0) push_item(KIND_BYTE, any_byte());
        push_item(KIND_BYTE, CH_CR);
        push_item(KIND_BYTE, CH_LF);
        sel = $urandom_range(0, 9);
        if (sel < 6)
            body_n = $urandom_range(0, 10);
        else if (sel < 9)
            body_n = $urandom_range(11, 30);
        else
            body_n = $urandom_range(31, 80);
        for (int j = 0; j < body_n; j++) begin
            if ($urandom_range(0, 19) == 0) push_noise();
            push_item(KIND_BYTE, any_byte());
        end
    endfunction

    initial begin : stimulus
        logic [15:0] caps [9];
        item_t       it;
        int          phase_items;
        bit          first_resp;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 16'd0;
        in_ch.valid   <= 1'b0;
        in_ch.kind    <= KIND_BYTE;
        in_ch.rx_byte <= 8'h00;
        pin_flag      <= 1'b0;
        pin_res       <= '0;
        hold_asked    <= 0;
        mismatch_n    = 0;
        src_calm      = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, small capacity so the body fills quickly
        set_capacity(16'd3);
        foreach (DIR_TABLE[k]) send_item(DIR_TABLE[k]);

        // extremes first, then a few small and random settings; a phase may
        // open without a start so a new capacity lands mid-body
        caps = '{16'd1, 16'hffff, 16'd0, 16'd4096, 16'd2, 16'd17, 16'd5, 16'd0, 16'd0};
        caps[7] = 16'($urandom_range(1, 64));
        caps[8] = 16'($urandom_range(1, 65535));

        foreach (caps[p]) begin
            set_capacity(caps[p]);
            phase_items = 0;
            first_resp  = 1'b1;
            while (phase_items < ITEMS_PER_PHASE) begin
                src_calm = ($urandom_range(0, 3) == 0);
                // receiver holds off while the sender keeps offering
                if (first_resp && p == HOLD_PHASE) begin
                    src_calm = 1'b1;
                    hold_asked <= hold_asked + 1;
                end
                build_response(first_resp ? $urandom_range(0, 1) : ($urandom_range(0, 7) != 0));
                first_resp = 1'b0;
                while (resp_q.size() > 0) begin
                    it = resp_q.pop_front();
                    if (it.kind != KIND_UNUSED) phase_items++;
                    send_item(it);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_n == 0 && expect_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/hrhs_pkg.sv
hw/rtl/hrhs_if.sv
hw/rtl/hrhs_win_cell.sv
hw/rtl/http_response_header_scanner_core.sv
tb/http_response_header_scanner_core_test.sv
